// File: hdl/tail_drop_packet_buffer_assert.svh
// Assertion helpers shared by the buffer RTL.
`ifndef TAIL_DROP_PACKET_BUFFER_ASSERT_SVH
`define TAIL_DROP_PACKET_BUFFER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TDPB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdpb check failed");

// Next-cycle implication, checked out of reset.
`define TDPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdpb check failed");

`endif

// File: hdl/tdpb_pkg.sv
package tdpb_pkg;

  // Shared adder operation select
  localparam logic OP_CMP = 1'b0;  // arrival - head finish, carry set when head <= arrival
  localparam logic OP_ADD = 1'b1;  // start + process time, carry set on overflow

  // Control from the sequencer to the finish-time queue
  typedef struct packed {
    logic pop;
    logic push;
  } q_ctrl_t;

endpackage

// File: hdl/tail_drop_packet_buffer.sv
// Flow: an accepted item moves to S_CHK, which retires queued packets whose finish is at
//   or before its arrival, then posts a drop or moves to S_PUSH; out_stall can hold either.
// The input is stalled until the item is through (back in S_IDLE); one head entry is checked per
//   cycle via the single memory read port and the one shared adder/comparator.
// Retires are amortised: each packet is popped once.
// Reset (rst, synchronous): queue empty, capacity 16, no result pending; memory not cleared.
`include "tail_drop_packet_buffer_assert.svh"

module tail_drop_packet_buffer import tdpb_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: buffer_capacity
  input  logic        cfg_write,
  input  logic [4:0]  cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] pkt_arrival,
  input  logic [15:0] pkt_service,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] start_time,
  output logic        dropped
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] S_CHK  = 2'd1;  // retire head entries, then drop or pick start
  localparam logic [1:0] S_PUSH = 2'd2;  // add process time, push finish, post result

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [4:0]           buffer_capacity;

  // item held while it is worked on
  logic [TIME_BITS-1:0] arr;
  logic [15:0]          proc;
  logic [TIME_BITS-1:0] start;

  // queue interface
  q_ctrl_t              q_ctrl;
  logic [TIME_BITS-1:0] q_head;
  logic [TIME_BITS-1:0] q_last;
  logic [CNT_W-1:0]     q_count;
  logic [TIME_BITS-1:0] finish;

  // shared adder: used as comparator in S_CHK and as adder in S_PUSH
  logic                 op;
  logic [TIME_BITS-1:0] op_a;
  logic [TIME_BITS-1:0] op_b;
  logic [TIME_BITS:0]   op_sum;
  logic                 op_carry;

  // capacity clamped to 1..QUEUE_DEPTH
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_eff;
  logic [CMP_W-1:0]     count_ext;

  logic                 in_take;
  logic                 out_free;
  logic                 head_done;
  logic                 is_full;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cap_ext = CMP_W'(buffer_capacity);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(QUEUE_DEPTH)) begin
      cap_eff = CMP_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign count_ext = CMP_W'(q_count);
  assign is_full   = (count_ext >= cap_eff);

  // a - b as a + ~b + 1 for the compare; carry out means head finish <= arrival
  assign op   = (state == S_PUSH) ? OP_ADD : OP_CMP;
  assign op_a = (op == OP_ADD) ? start : arr;
  assign op_b = (op == OP_ADD) ? TIME_BITS'(proc) : ~q_head;
  assign op_sum = {1'b0, op_a} + {1'b0, op_b} + (TIME_BITS + 1)'(op == OP_CMP);
  assign op_carry = op_sum[TIME_BITS];

  // head retires when queue not empty and its finish is at or before arrival
  assign head_done = (q_count != '0) && op_carry;

  // saturating finish time
  assign finish = op_carry ? '1 : op_sum[TIME_BITS-1:0];

  always_comb begin
    state_next  = state;
    q_ctrl.pop  = 1'b0;
    q_ctrl.push = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (head_done) begin
          q_ctrl.pop = 1'b1;
        end else if (is_full) begin
          if (out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          q_ctrl.push = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      buffer_capacity <= 5'd16;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        buffer_capacity <= cfg_data;
      end
      if ((state == S_CHK && !head_done && is_full && out_free) ||
          (state == S_PUSH && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      arr  <= TIME_BITS'(pkt_arrival);
      proc <= pkt_service;
    end
    if (state == S_CHK && !head_done && !is_full) begin
      start <= (q_count == '0) ? arr : q_last;
    end
    if (state == S_CHK && !head_done && is_full && out_free) begin
      start_time <= '0;
      dropped    <= 1'b1;
    end
    if (state == S_PUSH && out_free) begin
      start_time <= 32'(start);
      dropped    <= 1'b0;
    end
  end

  tdpb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .CNT_W       (CNT_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (q_ctrl),
    .push_data (finish),
    .head_data (q_head),
    .last_data (q_last),
    .count     (q_count)
  );

  `TDPB_ASSERT_NOW(a_push_room, clk, rst, q_ctrl.push, count_ext < cap_eff)
  `TDPB_ASSERT_NOW(a_pop_in_chk, clk, rst, q_ctrl.pop, state == S_CHK && !q_ctrl.push)
  `TDPB_ASSERT_NEXT(a_push_result, clk, rst, q_ctrl.push, out_valid && !dropped)

endmodule

// File: hdl/tdpb_queue.sv
`include "tail_drop_packet_buffer_assert.svh"

module tdpb_queue import tdpb_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  q_ctrl_t              ctrl,
  input  logic [TIME_BITS-1:0] push_data,
  output logic [TIME_BITS-1:0] head_data,
  output logic [TIME_BITS-1:0] last_data,
  output logic [CNT_W-1:0]     count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [TIME_BITS-1:0] mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]     head_slot;
  logic [IDX_W-1:0]     head_slot_next;
  logic [IDX_W-1:0]     tail_slot;
  logic [CNT_W-1:0]     count_next;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] s);
    if (s == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return s + IDX_W'(1);
  endfunction

  assign head_slot_next = ctrl.pop ? wrap_inc(head_slot) : head_slot;

  always_comb begin
    count_next = count;
    if (ctrl.push && !ctrl.pop) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop && !ctrl.push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot <= '0;
      tail_slot <= '0;
      count     <= '0;
    end else begin
      head_slot <= head_slot_next;
      count     <= count_next;
      if (ctrl.push) begin
        tail_slot <= wrap_inc(tail_slot);
      end
    end
  end

  // read port follows the head so the new head is ready the cycle after a pop
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_slot] <= push_data;
    end
    head_data <= mem[head_slot_next];
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      last_data <= push_data;
    end
  end

  `TDPB_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `TDPB_ASSERT_NOW(a_pop_nonempty, clk, rst, ctrl.pop, count != '0)
  `TDPB_ASSERT_NEXT(a_push_grows, clk, rst, ctrl.push && !ctrl.pop,
                    count == $past(count) + CNT_W'(1))

endmodule
